// ===== hw/rtl/pru_pkg.sv =====
package pru_pkg;

	localparam logic [31:0] QNAN        = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF     = 32'h7F80_0000;
	localparam logic [31:0] RSQRT_MAGIC = 32'h5F37_5A86;
	localparam logic [31:0] NEG_HALF    = 32'hBF00_0000;
	localparam logic [31:0] ONE_HALF    = 32'h3FC0_0000;
	localparam logic [31:0] ONE         = 32'h3F80_0000;
	localparam logic [31:0] TWO_P24     = 32'h4B80_0000;
	localparam logic [31:0] TWO_P12     = 32'h4580_0000;

	localparam int MUL_LAT       = 2;
	localparam int ADD_LAT       = 2;
	localparam int NEWTON_STEPS  = 3;
	localparam int NEWTON_LAT    = 3 * MUL_LAT + ADD_LAT;
	localparam int RSQRT_LAT     = 2 * MUL_LAT + NEWTON_STEPS * NEWTON_LAT + 1;

	typedef enum logic [1:0] {
		CFG_SD_INV_MAX = 2'd0,
		CFG_CLIP_MIN   = 2'd1,
		CFG_CLIP_MAX   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_DIFF = 2'd0,
		MODE_ZERO = 2'd1,
		MODE_MAC  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// value = mant * 2^(exp - 175); fp_round normalizes the hidden bit to mant[48]
	typedef struct packed {
		logic               special;
		logic [31:0]        val;
		logic               sign;
		logic signed [11:0] exp;
		logic [49:0]        mant;
	} fp_raw_t;

	function automatic logic fp_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic fp_is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic fp_is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (fp_is_zero(a) && fp_is_zero(b))
			r = 1'b0;
		else if (a[31] != b[31])
			r = a[31];
		else if (!a[31])
			r = a[30:0] < b[30:0];
		else
			r = a[30:0] > b[30:0];
		return r;
	endfunction

	function automatic logic [31:0] fp_min(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (fp_is_nan(a) || fp_is_nan(b))
			r = QNAN;
		else
			r = fp_lt(b, a) ? b : a;
		return r;
	endfunction

	function automatic logic [31:0] fp_max(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (fp_is_nan(a) || fp_is_nan(b))
			r = QNAN;
		else
			r = fp_lt(a, b) ? b : a;
		return r;
	endfunction

	function automatic fp_raw_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
		fp_raw_t     r;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [9:0]  ea;
		logic [9:0]  eb;
		logic [47:0] prod;
		r.special = 1'b0;
		r.val     = QNAN;
		r.sign    = a[31] ^ b[31];
		r.exp     = 12'sd0;
		r.mant    = 50'd0;
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		ea = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
		eb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
		prod = ma * mb;
		if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b)) ||
				(fp_is_inf(b) && fp_is_zero(a))) begin
			r.special = 1'b1;
			r.val     = QNAN;
		end else if (fp_is_inf(a) || fp_is_inf(b)) begin
			r.special = 1'b1;
			r.val     = {r.sign, 8'hFF, 23'd0};
		end else begin
			r.mant = {2'b00, prod};
			r.exp  = $signed({2'b00, ea} + {2'b00, eb}) - 12'sd125;
		end
		return r;
	endfunction

	function automatic fp_raw_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
		fp_raw_t      r;
		logic [31:0]  big;
		logic [31:0]  sml;
		logic [7:0]   eb8;
		logic [7:0]   es8;
		logic [7:0]   dd;
		logic [6:0]   sh;
		logic [99:0]  full;
		logic [50:0]  mb51;
		logic [50:0]  ms51;
		logic [50:0]  sum51;
		r.special = 1'b0;
		r.val     = QNAN;
		r.sign    = 1'b0;
		r.exp     = 12'sd0;
		r.mant    = 50'd0;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb8 = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es8 = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		dd  = eb8 - es8;
		sh  = (dd[7] || dd[6]) ? 7'd63 : {1'b0, dd[5:0]};
		full  = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 25'd0, 50'd0} >> sh;
		mb51  = {1'b0, (big[30:23] != 8'd0), big[22:0], 25'd0, 1'b0};
		ms51  = {full[99:50], |full[49:0]};
		sum51 = (a[31] ^ b[31]) ? (mb51 - ms51) : (mb51 + ms51);
		if (fp_is_nan(a) || fp_is_nan(b) ||
				(fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))) begin
			r.special = 1'b1;
			r.val     = QNAN;
		end else if (fp_is_inf(a)) begin
			r.special = 1'b1;
			r.val     = a;
		end else if (fp_is_inf(b)) begin
			r.special = 1'b1;
			r.val     = b;
		end else begin
			r.mant = {sum51[50:2], sum51[1] | sum51[0]};
			r.exp  = $signed({4'd0, eb8});
			r.sign = (sum51 == 51'd0) ? (a[31] & b[31]) : big[31];
		end
		return r;
	endfunction

	// normalize, round to nearest even, pack
	function automatic logic [31:0] fp_round(input fp_raw_t r);
		logic [49:0]        m;
		logic signed [12:0] e;
		logic signed [12:0] dsh;
		logic [5:0]         p;
		logic               stk;
		logic               inc;
		logic [24:0]        m24;
		logic [12:0]        fexp;
		logic [35:0]        tot;
		logic [31:0]        y;
		p = 6'd0;
		for (int i = 0; i < 50; i++)
			if (r.mant[i])
				p = 6'(i);
		m   = r.mant;
		e   = 13'(r.exp);
		stk = 1'b0;
		if (p == 6'd49) begin
			m = {1'b0, r.mant[49:2], r.mant[1] | r.mant[0]};
			e = e + 13'sd1;
		end else begin
			m = r.mant << (6'd48 - p);
			e = e - $signed({7'd0, 6'd48 - p});
		end
		if (e < 13'sd1) begin
			dsh = 13'sd1 - e;
			if (dsh > 13'sd49) begin
				m = {49'd0, |m};
			end else begin
				stk = |(m & ((50'd1 << dsh[5:0]) - 50'd1));
				m   = (m >> dsh[5:0]) | {49'd0, stk};
			end
			e = 13'sd0;
		end
		inc  = m[24] & ((|m[23:0]) | m[25]);
		m24  = {1'b0, m[48:25]} + {24'd0, inc};
		fexp = (e == 13'sd0) ? 13'd0 : 13'(e - 13'sd1);
		tot  = {fexp, 23'd0} + {11'd0, m24};
		if (r.special)
			y = r.val;
		else if (r.mant == 50'd0)
			y = {r.sign, 31'd0};
		else if (tot >= {13'd255, 23'd0})
			y = {r.sign, 8'hFF, 23'd0};
		else
			y = {r.sign, tot[30:0]};
		return y;
	endfunction

endpackage

// ===== hw/rtl/pru_fmul.sv =====
module pru_fmul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	pru_pkg::fp_raw_t raw_s1;
	logic [31:0]      y_s2;

	always_ff @(posedge clk) begin
		raw_s1 <= pru_pkg::fp_mul_pre(a, b);
		y_s2   <= pru_pkg::fp_round(raw_s1);
	end

	assign y = y_s2;

endmodule

// ===== hw/rtl/pru_fadd.sv =====
module pru_fadd (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	pru_pkg::fp_raw_t raw_s1;
	logic [31:0]      y_s2;

	always_ff @(posedge clk) begin
		raw_s1 <= pru_pkg::fp_add_pre(a, b);
		y_s2   <= pru_pkg::fp_round(raw_s1);
	end

	assign y = y_s2;

endmodule

// ===== hw/rtl/pru_newton.sv =====
module pru_newton (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] x,
	output logic [31:0] x_next
);

	localparam int XD = 2 * pru_pkg::MUL_LAT + pru_pkg::ADD_LAT;

	logic [31:0] h;
	logic [31:0] t;
	logic [31:0] u;
	logic [31:0] s;
	logic [31:0] x_q [1:XD];

	always_ff @(posedge clk) begin
		x_q[1] <= x;
		for (int i = 2; i <= XD; i++)
			x_q[i] <= x_q[i-1];
	end

	pru_fmul u_h (.clk(clk), .a(pru_pkg::NEG_HALF), .b(x), .y(h));
	pru_fmul u_t (.clk(clk), .a(a), .b(x), .y(t));
	pru_fmul u_u (.clk(clk), .a(h), .b(t), .y(u));
	pru_fadd u_s (.clk(clk), .a(u), .b(pru_pkg::ONE_HALF), .y(s));
	pru_fmul u_x (.clk(clk), .a(x_q[XD]), .b(s), .y(x_next));

endmodule

// ===== hw/rtl/pru_rsqrt.sv =====
module pru_rsqrt (
	input  logic        clk,
	input  logic [31:0] a,
	output logic [31:0] y
);

	localparam int FL_N   = pru_pkg::RSQRT_LAT - 1;
	localparam int SUB_TAP = pru_pkg::MUL_LAT + pru_pkg::NEWTON_STEPS * pru_pkg::NEWTON_LAT;
	localparam int AD_N   = (pru_pkg::NEWTON_STEPS - 1) * pru_pkg::NEWTON_LAT;

	typedef struct packed {
		logic is_nan;
		logic is_zero;
		logic is_inf;
		logic is_sub;
	} rs_flags_t;

	rs_flags_t   fl_now;
	rs_flags_t   fl_q [1:FL_N];
	logic [31:0] a1;
	logic [31:0] ad_q [1:AD_N];
	logic [31:0] a_in [0:pru_pkg::NEWTON_STEPS-1];
	logic [31:0] x_in [0:pru_pkg::NEWTON_STEPS];
	logic [31:0] ys;
	logic [31:0] y_q;

	always_comb begin
		fl_now.is_nan  = pru_pkg::fp_is_nan(a) || (a[31] && !pru_pkg::fp_is_zero(a));
		fl_now.is_zero = pru_pkg::fp_is_zero(a);
		fl_now.is_inf  = (a == pru_pkg::POS_INF);
		fl_now.is_sub  = (a[30:23] == 8'd0) && !pru_pkg::fp_is_zero(a);
	end

	always_ff @(posedge clk) begin
		fl_q[1] <= fl_now;
		for (int i = 2; i <= FL_N; i++)
			fl_q[i] <= fl_q[i-1];
		ad_q[1] <= a1;
		for (int i = 2; i <= AD_N; i++)
			ad_q[i] <= ad_q[i-1];
	end

	pru_fmul u_pre (
		.clk(clk), .a(a),
		.b(fl_now.is_sub ? pru_pkg::TWO_P24 : pru_pkg::ONE), .y(a1)
	);

	assign x_in[0] = pru_pkg::RSQRT_MAGIC - {1'b0, a1[31:1]};
	assign a_in[0] = a1;

	for (genvar g = 0; g < pru_pkg::NEWTON_STEPS; g++) begin : g_step
		if (g > 0) begin : g_tap
			assign a_in[g] = ad_q[g * pru_pkg::NEWTON_LAT];
		end
		pru_newton u_nt (.clk(clk), .a(a_in[g]), .x(x_in[g]), .x_next(x_in[g+1]));
	end

	pru_fmul u_scl (
		.clk(clk), .a(x_in[pru_pkg::NEWTON_STEPS]),
		.b(fl_q[SUB_TAP].is_sub ? pru_pkg::TWO_P12 : pru_pkg::ONE), .y(ys)
	);

	always_ff @(posedge clk) begin
		if (fl_q[FL_N].is_nan)
			y_q <= pru_pkg::QNAN;
		else if (fl_q[FL_N].is_zero)
			y_q <= pru_pkg::POS_INF;
		else if (fl_q[FL_N].is_inf)
			y_q <= 32'd0;
		else
			y_q <= ys;
	end

	assign y = y_q;

endmodule

// ===== hw/rtl/pearson_residual_unit_top.sv =====
// Channel   Signals                                         Direction
// input     start, busy, mode, count_value, size_factor,    in (busy out)
//           gene_factor, inverse_theta, vector_entry,
//           accumulator
// result    done, residual                                  out
// config    cfg_we, cfg_index, cfg_data                     in
//
// One transaction accepted per cycle; busy is never raised.
// The path from accept to done runs through the chain of
// two-stage multipliers and adders: mu, var, rsqrt (prescale, three Newton
// steps, scale), residual multiply, clamp, final add.
// arst_n clears the valid pipeline and loads the config reset values.
// done pulses for one cycle; the receiver cannot stall.
module pearson_residual_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] count_value,
	input  logic [31:0] size_factor,
	input  logic [31:0] gene_factor,
	input  logic [31:0] inverse_theta,
	input  logic [31:0] vector_entry,
	input  logic [31:0] accumulator,
	output logic        done,
	output logic [31:0] residual,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int T_MU  = pru_pkg::MUL_LAT;
	localparam int T_D   = T_MU + pru_pkg::ADD_LAT;
	localparam int T_T1  = T_MU + pru_pkg::MUL_LAT;
	localparam int T_T2  = T_T1 + pru_pkg::MUL_LAT;
	localparam int T_VAR = T_T2 + pru_pkg::ADD_LAT;
	localparam int T_RS  = T_VAR + pru_pkg::RSQRT_LAT;
	localparam int T_SD  = T_RS + 1;
	localparam int T_NM  = T_SD + pru_pkg::MUL_LAT;
	localparam int T_Z   = T_NM + 1;
	localparam int T_P   = T_Z + pru_pkg::MUL_LAT;
	localparam int T_SUM = T_P + pru_pkg::ADD_LAT;
	localparam int T_OUT = T_SUM + 1;

	localparam int MU_N = T_SD - T_MU;
	localparam int D_N  = T_SD - T_D;
	localparam int Z_N  = T_SUM - T_Z;
	localparam int V_N  = T_P - T_Z;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] vec;
		logic [31:0] acc;
	} side_t;

	logic [31:0] sd_inv_max_q;
	logic [31:0] clip_min_q;
	logic [31:0] clip_max_q;

	logic        vld_q [0:T_OUT];
	side_t       side_s0;
	logic [31:0] x_s0;
	logic [31:0] cell_s0;
	logic [31:0] gene_s0;
	logic [31:0] th_s0;

	logic [63:0] xth_q  [1:T_MU];
	side_t       side_q [1:T_SUM];
	logic [31:0] mu_q   [1:MU_N];
	logic [31:0] d_q    [1:D_N];
	logic [31:0] z_q    [1:Z_N];
	logic [31:0] val_q  [1:V_N];

	logic [31:0] mu;
	logic [31:0] d;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] var_v;
	logic [31:0] rs;
	logic [31:0] sd_s38;
	logic [31:0] nm;
	logic [31:0] val0;
	logic [31:0] z_s41;
	logic [31:0] val_s41;
	logic [31:0] p;
	logic [31:0] fa;
	logic [31:0] fb;
	logic [31:0] sum;
	logic [31:0] res_s46;
	side_t       side_p;
	side_t       side_e;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_inv_max_q <= 32'h7F80_0000;
			clip_min_q   <= 32'hFF80_0000;
			clip_max_q   <= 32'h7F80_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				pru_pkg::CFG_SD_INV_MAX: sd_inv_max_q <= cfg_data;
				pru_pkg::CFG_CLIP_MIN:   clip_min_q   <= cfg_data;
				pru_pkg::CFG_CLIP_MAX:   clip_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= T_OUT; i++)
				vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i <= T_OUT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s0 <= '{mode: mode, vec: vector_entry, acc: accumulator};
		x_s0    <= count_value;
		cell_s0 <= size_factor;
		gene_s0 <= gene_factor;
		th_s0   <= inverse_theta;
	end

	always_ff @(posedge clk) begin
		xth_q[1] <= {x_s0, th_s0};
		for (int i = 2; i <= T_MU; i++)
			xth_q[i] <= xth_q[i-1];
		side_q[1] <= side_s0;
		for (int i = 2; i <= T_SUM; i++)
			side_q[i] <= side_q[i-1];
		mu_q[1] <= mu;
		for (int i = 2; i <= MU_N; i++)
			mu_q[i] <= mu_q[i-1];
		d_q[1] <= d;
		for (int i = 2; i <= D_N; i++)
			d_q[i] <= d_q[i-1];
		z_q[1] <= z_s41;
		for (int i = 2; i <= Z_N; i++)
			z_q[i] <= z_q[i-1];
		val_q[1] <= val_s41;
		for (int i = 2; i <= V_N; i++)
			val_q[i] <= val_q[i-1];
	end

	pru_fmul u_mu (.clk(clk), .a(cell_s0), .b(gene_s0), .y(mu));
	pru_fadd u_d (
		.clk(clk), .a(xth_q[T_MU][63:32]), .b({~mu[31], mu[30:0]}), .y(d)
	);
	pru_fmul u_t1 (.clk(clk), .a(mu), .b(xth_q[T_MU][31:0]), .y(t1));
	pru_fmul u_t2 (.clk(clk), .a(t1), .b(mu_q[T_T1 - T_MU]), .y(t2));
	pru_fadd u_var (.clk(clk), .a(t2), .b(mu_q[T_T2 - T_MU]), .y(var_v));

	pru_rsqrt u_rs (.clk(clk), .a(var_v), .y(rs));

	always_ff @(posedge clk) begin
		sd_s38 <= pru_pkg::fp_min(sd_inv_max_q, rs);
	end

	pru_fmul u_nm (
		.clk(clk), .a({~mu_q[MU_N][31], mu_q[MU_N][30:0]}), .b(sd_s38), .y(nm)
	);
	pru_fmul u_val (.clk(clk), .a(d_q[D_N]), .b(sd_s38), .y(val0));

	always_ff @(posedge clk) begin
		z_s41   <= pru_pkg::fp_max(nm, clip_min_q);
		val_s41 <= pru_pkg::fp_min(pru_pkg::fp_max(val0, clip_min_q), clip_max_q);
	end

	pru_fmul u_p (.clk(clk), .a(side_q[T_Z].vec), .b(z_s41), .y(p));

	assign side_p = side_q[T_P];
	assign side_e = side_q[T_SUM];

	always_comb begin
		if (side_p.mode == pru_pkg::MODE_MAC) begin
			fa = p;
			fb = side_p.acc;
		end else begin
			fa = val_q[V_N];
			fb = {~z_q[V_N][31], z_q[V_N][30:0]};
		end
	end

	pru_fadd u_sum (.clk(clk), .a(fa), .b(fb), .y(sum));

	always_ff @(posedge clk) begin
		case (side_e.mode)
			pru_pkg::MODE_DIFF, pru_pkg::MODE_MAC:
				res_s46 <= pru_pkg::fp_is_nan(sum) ? pru_pkg::QNAN : sum;
			pru_pkg::MODE_ZERO:
				res_s46 <= pru_pkg::fp_is_nan(z_q[Z_N]) ? pru_pkg::QNAN : z_q[Z_N];
			default:
				res_s46 <= 32'd0;
		endcase
	end

	assign done     = vld_q[T_OUT];
	assign residual = res_s46;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(T_OUT + 1) done)
		else $error("accepted transaction did not complete on time");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(T_OUT + 1) !done)
		else $error("result without an accepted transaction");

	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == pru_pkg::MODE_NONE) |-> ##(T_OUT + 1)
			(residual == 32'd0))
		else $error("unused mode gave a nonzero result");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (residual[30:23] != 8'hFF || residual[22:0] == 23'd0 ||
			residual == pru_pkg::QNAN))
		else $error("non-canonical NaN on residual");

endmodule
